/* hw/rtl/ppsr_pkg.sv */
package ppsr_pkg;

  // command codes
  typedef enum logic [1:0] {
    CMD_RECT  = 2'd0,
    CMD_TRI   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  // fill modes, the last code draws nothing
  typedef enum logic [1:0] {
    MODE_FULL        = 2'd0,
    MODE_OUTLINE     = 2'd1,
    MODE_TRI_OUTLINE = 2'd2,
    MODE_NONE        = 2'd3
  } mode_t;

  // triangle direction
  typedef enum logic [1:0] {
    ORI_RIGHT = 2'd0,
    ORI_LEFT  = 2'd1,
    ORI_DOWN  = 2'd2,
    ORI_UP    = 2'd3
  } orient_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RDATA,
    S_PIX,
    S_WR,
    S_DONE
  } state_t;

  // signed pixel coordinate: start point, stripe offset and box offset together
  localparam int COORD_W = 11;

endpackage

/* hw/rtl/page_packed_shape_rasterizer.sv */
// flow: one transaction at a time; the frame store does one read-modify-write per plotted
//   pixel, and a finished transaction waits in its completion state while the previous
//   result is still held for out_ready
// reset: the frame store is swept to zero, one byte a cycle, through all FRAME_BYTES bytes
module page_packed_shape_rasterizer #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        cmd,
  input  logic signed [8:0] pos_x,
  input  logic signed [8:0] pos_y,
  input  logic [7:0]        width_px,
  input  logic [7:0]        height_px,
  input  logic [7:0]        side_len,
  input  logic [1:0]        orientation,
  input  logic [1:0]        fill_mode,
  input  logic [9:0]        read_addr,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        read_byte,
  output logic              clipped
);

  localparam int FRAME_BYTES = SCREEN_WIDTH * ((SCREEN_HEIGHT + 7) / 8);
  localparam int ADDR_W      = $clog2(FRAME_BYTES);
  localparam int CW          = ppsr_pkg::COORD_W;
  localparam logic signed [CW-1:0] X_MAX = CW'(SCREEN_WIDTH - 1);
  localparam logic signed [CW-1:0] Y_MAX = CW'(SCREEN_HEIGHT - 1);
  localparam logic [ADDR_W-1:0] LAST_BYTE = ADDR_W'(FRAME_BYTES - 1);

  ppsr_pkg::state_t state, state_next;

  // control registers
  logic              out_valid_next;
  logic              clr_reply, clr_reply_next;
  logic [ADDR_W-1:0] clr_cnt, clr_cnt_next;

  // shape registers: current box (a rectangle or one triangle stripe)
  logic signed [CW-1:0] bx, bx_next, by, by_next;
  logic [7:0]  bw, bw_next, bh, bh_next;
  logic [7:0]  ci, ci_next, cj, cj_next;
  logic [7:0]  n_left, n_left_next;
  logic        is_tri, is_tri_next;
  logic        solid, solid_next;
  logic [1:0]  ori, ori_next;
  logic [1:0]  mode, mode_next;
  logic        rd_ok, rd_ok_next;
  logic        clip, clip_next;
  logic [7:0]  res_byte, res_byte_next;
  logic [ADDR_W-1:0] wr_addr, wr_addr_next;
  logic [7:0]  wr_mask, wr_mask_next;
  logic [7:0]  read_byte_next;
  logic        clipped_next;

  // frame store port
  logic [7:0]        mem [FRAME_BYTES];
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rdata;
  logic              we;
  logic [ADDR_W-1:0] wa;
  logic [7:0]        wd;

  // pixel unit: coordinate, screen test, page address, bit mask, fill rule
  logic signed [CW-1:0] px, py;
  logic              onscr;
  logic              last_i, last_j;
  logic              pix_on;
  logic [ADDR_W-1:0] pix_addr;
  logic [7:0]        pix_mask;
  logic              vertical;
  logic              do_adv;

  assign px       = bx + CW'(ci);
  assign py       = by + CW'(cj);
  assign onscr    = (px >= 0) && (py >= 0) && (px <= X_MAX) && (py <= Y_MAX);
  assign last_i   = (ci == bw - 8'd1);
  assign last_j   = (cj == bh - 8'd1);
  // page of eight rows times the row pitch, plus column
  assign pix_addr = ADDR_W'(32'(py[CW-1:3]) * SCREEN_WIDTH + 32'(px[CW-2:0]));
  assign pix_mask = 8'd1 << py[2:0];
  assign vertical = (ori == ppsr_pkg::ORI_RIGHT) || (ori == ppsr_pkg::ORI_LEFT);

  always_comb begin
    case (mode)
      ppsr_pkg::MODE_FULL:        pix_on = 1'b1;
      ppsr_pkg::MODE_OUTLINE:     pix_on = (ci == 8'd0) || (cj == 8'd0) || last_i || last_j;
      ppsr_pkg::MODE_TRI_OUTLINE: pix_on = solid || ((ci == 8'd0) && (cj == 8'd0)) ||
                                           (last_i && last_j);
      default:                    pix_on = 1'b0;
    endcase
  end

  // memory: read address follows the request in idle, else the pixel unit
  assign rd_addr = (state == ppsr_pkg::S_IDLE) ? ADDR_W'(read_addr) : pix_addr;
  assign we      = (state == ppsr_pkg::S_CLEAR) || (state == ppsr_pkg::S_WR);
  assign wa      = (state == ppsr_pkg::S_CLEAR) ? clr_cnt : wr_addr;
  assign wd      = (state == ppsr_pkg::S_CLEAR) ? 8'd0 : (rdata | wr_mask);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata <= mem[rd_addr];
  end

  assign in_ready = (state == ppsr_pkg::S_IDLE);

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && !out_ready;
    clr_reply_next = clr_reply;
    clr_cnt_next   = clr_cnt;
    bx_next        = bx;
    by_next        = by;
    bw_next        = bw;
    bh_next        = bh;
    ci_next        = ci;
    cj_next        = cj;
    n_left_next    = n_left;
    is_tri_next    = is_tri;
    solid_next     = solid;
    ori_next       = ori;
    mode_next      = mode;
    rd_ok_next     = rd_ok;
    clip_next      = clip;
    res_byte_next  = res_byte;
    wr_addr_next   = wr_addr;
    wr_mask_next   = wr_mask;
    read_byte_next = read_byte;
    clipped_next   = clipped;
    do_adv         = 1'b0;

    case (state)
      ppsr_pkg::S_CLEAR: begin
        if (clr_cnt == LAST_BYTE) begin
          state_next     = clr_reply ? ppsr_pkg::S_DONE : ppsr_pkg::S_IDLE;
          clr_reply_next = 1'b0;
          res_byte_next  = 8'd0;
          clip_next      = 1'b0;
        end else begin
          clr_cnt_next = clr_cnt + 1'b1;
        end
      end

      ppsr_pkg::S_IDLE: begin
        if (in_valid) begin
          clip_next     = 1'b0;
          res_byte_next = 8'd0;
          mode_next     = fill_mode;
          ori_next      = orientation;
          ci_next       = 8'd0;
          cj_next       = 8'd0;
          bx_next       = CW'(pos_x);
          by_next       = CW'(pos_y);
          case (cmd)
            ppsr_pkg::CMD_RECT: begin
              is_tri_next = 1'b0;
              solid_next  = 1'b0;
              bw_next     = width_px;
              bh_next     = height_px;
              if ((width_px == 8'd0) || (height_px == 8'd0) ||
                  (fill_mode == ppsr_pkg::MODE_NONE)) begin
                state_next = ppsr_pkg::S_DONE;
              end else begin
                state_next = ppsr_pkg::S_PIX;
              end
            end
            ppsr_pkg::CMD_TRI: begin
              // first stripe is solid
              is_tri_next = 1'b1;
              solid_next  = 1'b1;
              n_left_next = side_len;
              if (orientation inside {ppsr_pkg::ORI_RIGHT, ppsr_pkg::ORI_LEFT}) begin
                bw_next = 8'd1;
                bh_next = side_len;
              end else begin
                bw_next = side_len;
                bh_next = 8'd1;
              end
              if ((side_len == 8'd0) || (fill_mode == ppsr_pkg::MODE_NONE)) begin
                state_next = ppsr_pkg::S_DONE;
              end else begin
                state_next = ppsr_pkg::S_PIX;
              end
            end
            ppsr_pkg::CMD_READ: begin
              rd_ok_next = (32'(read_addr) < FRAME_BYTES);
              state_next = ppsr_pkg::S_RDATA;
            end
            default: begin
              clr_cnt_next   = '0;
              clr_reply_next = 1'b1;
              state_next     = ppsr_pkg::S_CLEAR;
            end
          endcase
        end
      end

      ppsr_pkg::S_RDATA: begin
        res_byte_next = rd_ok ? rdata : 8'd0;
        state_next    = ppsr_pkg::S_DONE;
      end

      ppsr_pkg::S_PIX: begin
        if (pix_on && onscr) begin
          wr_addr_next = pix_addr;
          wr_mask_next = pix_mask;
          state_next   = ppsr_pkg::S_WR;
        end else begin
          if (pix_on) begin
            clip_next = 1'b1;
          end
          do_adv = 1'b1;
        end
      end

      ppsr_pkg::S_WR: begin
        do_adv = 1'b1;
      end

      ppsr_pkg::S_DONE: begin
        if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          read_byte_next = res_byte;
          clipped_next   = clip;
          state_next     = ppsr_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = ppsr_pkg::S_IDLE;
      end
    endcase

    // step through the box column by column, rows inner
    if (do_adv) begin
      state_next = ppsr_pkg::S_PIX;
      if (!last_j) begin
        cj_next = cj + 8'd1;
      end else begin
        cj_next = 8'd0;
        if (!last_i) begin
          ci_next = ci + 8'd1;
        end else begin
          ci_next = 8'd0;
          if (is_tri && (n_left > 8'd2)) begin
            // next stripe: two shorter, moved one step diagonally
            n_left_next = n_left - 8'd2;
            solid_next  = 1'b0;
            bx_next     = (ori == ppsr_pkg::ORI_LEFT) ? bx - CW'(1) : bx + CW'(1);
            by_next     = (ori == ppsr_pkg::ORI_UP)   ? by - CW'(1) : by + CW'(1);
            if (vertical) begin
              bh_next = n_left - 8'd2;
            end else begin
              bw_next = n_left - 8'd2;
            end
          end else begin
            state_next = ppsr_pkg::S_DONE;
          end
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ppsr_pkg::S_CLEAR;
      out_valid <= 1'b0;
      clr_reply <= 1'b0;
      clr_cnt   <= '0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      clr_reply <= clr_reply_next;
      clr_cnt   <= clr_cnt_next;
    end
  end

  // shape and result registers
  always_ff @(posedge clk) begin
    bx        <= bx_next;
    by        <= by_next;
    bw        <= bw_next;
    bh        <= bh_next;
    ci        <= ci_next;
    cj        <= cj_next;
    n_left    <= n_left_next;
    is_tri    <= is_tri_next;
    solid     <= solid_next;
    ori       <= ori_next;
    mode      <= mode_next;
    rd_ok     <= rd_ok_next;
    clip      <= clip_next;
    res_byte  <= res_byte_next;
    wr_addr   <= wr_addr_next;
    wr_mask   <= wr_mask_next;
    read_byte <= read_byte_next;
    clipped   <= clipped_next;
  end

  // frame store is written only by the clear sweep or a pixel update
  a_write_src: assert property (@(posedge clk) disable iff (rst)
    we |-> (state == ppsr_pkg::S_CLEAR) || (state == ppsr_pkg::S_WR))
    else $error("frame store written outside clear or pixel update");

  // a pixel update writes back the byte fetched in the cycle before
  a_rmw_addr: assert property (@(posedge clk) disable iff (rst)
    (state == ppsr_pkg::S_WR) |-> (wr_addr == $past(pix_addr)))
    else $error("read-modify-write address mismatch");

  // one transaction at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while busy");

  // a result appears only from the completion state
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ppsr_pkg::S_DONE))
    else $error("result raised outside completion");

  // a read result with pixels set never reports clipping
  a_read_clip: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (read_byte != 8'd0)) |-> !clipped)
    else $error("clipped set on a read result");

endmodule

/* tb/tb_page_packed_shape_rasterizer.sv */
`timescale 1ns / 100ps

module tb_page_packed_shape_rasterizer;

  localparam int SCR_W       = 128;
  localparam int SCR_H       = 64;
  localparam int FRAME_BYTES = SCR_W * ((SCR_H + 7) / 8);

  // the slowest single transaction is a full 255x255 box; the reset sweep and the
  // long receiver hold come on top of it
  localparam int STALL_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 1725;
  localparam int CALM_TAIL    = 150;
  localparam int LONG_HOLD    = 400;

  // one drawing command as offered to the block
  typedef struct {
    ppsr_pkg::cmd_t    op;
    logic signed [8:0] x;
    logic signed [8:0] y;
    logic [7:0]        w;
    logic [7:0]        h;
    logic [7:0]        side;
    ppsr_pkg::orient_t ori;
    ppsr_pkg::mode_t   mode;
    logic [9:0]        addr;
    bit                drain;   // sender waits for every result before offering this one
  } shape_req_t;

  // what the block must answer for one command
  typedef struct {
    logic [7:0] rd_val;
    logic       clip;
  } shape_ans_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        cmd = '0;
  logic signed [8:0] pos_x = '0;
  logic signed [8:0] pos_y = '0;
  logic [7:0]        width_px = '0;
  logic [7:0]        height_px = '0;
  logic [7:0]        side_len = '0;
  logic [1:0]        orientation = '0;
  logic [1:0]        fill_mode = '0;
  logic [9:0]        read_addr = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [7:0]        read_byte;
  logic              clipped;

  page_packed_shape_rasterizer #(
    .SCREEN_WIDTH (SCR_W),
    .SCREEN_HEIGHT(SCR_H)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .width_px   (width_px),
    .height_px  (height_px),
    .side_len   (side_len),
    .orientation(orientation),
    .fill_mode  (fill_mode),
    .read_addr  (read_addr),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .read_byte  (read_byte),
    .clipped    (clipped)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // frame predictor: a private copy of the page-packed frame store
  // ---------------------------------------------------------------------------
  logic [7:0] frame_model [0:FRAME_BYTES-1];

  initial begin
    for (int i = 0; i < FRAME_BYTES; i++) frame_model[i] = 8'h00;
  end

  // sets one pixel, returns 1 when it lay off screen
  function automatic bit set_pixel(int x, int y);
    if (x < 0 || y < 0 || x > SCR_W - 1 || y > SCR_H - 1) return 1'b1;
    frame_model[(y / 8) * SCR_W + x] |= 8'(1 << (y % 8));
    return 1'b0;
  endfunction

  // solid forces every pixel on in triangle-outline mode (first stripe)
  function automatic bit paint_box(int x0, int y0, int w, int h, ppsr_pkg::mode_t m,
                                   bit solid);
    bit off;
    bit on;
    int x1;
    int y1;
    off = 1'b0;
    x1  = x0 + w - 1;
    y1  = y0 + h - 1;
    for (int i = x0; i <= x1; i++) begin
      for (int j = y0; j <= y1; j++) begin
        case (m)
          ppsr_pkg::MODE_FULL:        on = 1'b1;
          ppsr_pkg::MODE_OUTLINE:     on = (i == x0) || (j == y0) || (i == x1) || (j == y1);
          ppsr_pkg::MODE_TRI_OUTLINE: on = solid || (i == x0 && j == y0) ||
                                           (i == x1 && j == y1);
          default:                    on = 1'b0;
        endcase
        if (on && set_pixel(i, j)) off = 1'b1;
      end
    end
    return off;
  endfunction

  // stripes shrink by two and step one pixel diagonally each time
  function automatic bit paint_triangle(int x, int y, int len, ppsr_pkg::orient_t o,
                                        ppsr_pkg::mode_t m);
    bit off;
    bit stripe_off;
    int n;
    off = 1'b0;
    for (int k = 0; len - 2 * k > 0; k++) begin
      n = len - 2 * k;
      case (o)
        ppsr_pkg::ORI_RIGHT: stripe_off = paint_box(x + k, y + k, 1, n, m, k == 0);
        ppsr_pkg::ORI_LEFT:  stripe_off = paint_box(x - k, y + k, 1, n, m, k == 0);
        ppsr_pkg::ORI_DOWN:  stripe_off = paint_box(x + k, y + k, n, 1, m, k == 0);
        default:             stripe_off = paint_box(x + k, y - k, n, 1, m, k == 0);
      endcase
      if (stripe_off) off = 1'b1;
    end
    return off;
  endfunction

  function automatic shape_ans_t render_command(shape_req_t q);
    shape_ans_t a;
    a.rd_val = 8'h00;
    a.clip   = 1'b0;
    case (q.op)
      ppsr_pkg::CMD_RECT:
        a.clip = paint_box(int'(q.x), int'(q.y), int'(q.w), int'(q.h), q.mode, 1'b0);
      ppsr_pkg::CMD_TRI:
        a.clip = paint_triangle(int'(q.x), int'(q.y), int'(q.side), q.ori, q.mode);
      ppsr_pkg::CMD_READ: begin
        if (int'(q.addr) < FRAME_BYTES) a.rd_val = frame_model[q.addr];
      end
      default: begin
        for (int i = 0; i < FRAME_BYTES; i++) frame_model[i] = 8'h00;
      end
    endcase
    return a;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  shape_req_t pend_q [$];
  shape_ans_t due_results [$];

  int last_x = 0;
  int last_y = 0;

  function automatic shape_req_t mk_req(ppsr_pkg::cmd_t op, int x, int y, int w, int h,
                                        int side, ppsr_pkg::orient_t o,
                                        ppsr_pkg::mode_t m, int a);
    shape_req_t q;
    q.op    = op;
    q.x     = 9'(x);
    q.y     = 9'(y);
    q.w     = 8'(w);
    q.h     = 8'(h);
    q.side  = 8'(side);
    q.ori   = o;
    q.mode  = m;
    q.addr  = 10'(a);
    q.drain = 1'b0;
    return q;
  endfunction

  // fields the command ignores still carry random bits, so every bit toggles
  function automatic shape_req_t random_req();
    shape_req_t q;
    int r;
    q.x     = 9'($urandom);
    q.y     = 9'($urandom);
    q.w     = 8'($urandom);
    q.h     = 8'($urandom);
    q.side  = 8'($urandom);
    q.ori   = ppsr_pkg::orient_t'($urandom_range(0, 3));
    q.mode  = ppsr_pkg::mode_t'($urandom_range(0, 3));
    q.addr  = 10'($urandom);
    q.drain = 1'b0;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      // mostly close to the screen, so edges and corners clip often
      if ($urandom_range(0, 7) != 0) begin
        q.x = 9'($urandom_range(0, 159) - 16);
        q.y = 9'($urandom_range(0, 95) - 16);
      end
      if ($urandom_range(0, 15) == 0) q.mode = ppsr_pkg::MODE_NONE;
      else q.mode = ppsr_pkg::mode_t'($urandom_range(0, 2));
      last_x = int'(q.x);
      last_y = int'(q.y);
    end
    if (r < 30) begin
      q.op = ppsr_pkg::CMD_RECT;
      q.w  = 8'($urandom_range(0, 12));
      q.h  = 8'($urandom_range(0, 12));
      // now and then one long thin side
      if ($urandom_range(0, 15) == 0) begin
        if ($urandom_range(0, 1) == 0) begin
          q.w = 8'($urandom_range(0, 255));
          q.h = 8'($urandom_range(0, 8));
        end else begin
          q.h = 8'($urandom_range(0, 255));
          q.w = 8'($urandom_range(0, 8));
        end
      end
    end else if (r < 60) begin
      q.op   = ppsr_pkg::CMD_TRI;
      q.side = 8'($urandom_range(0, 24));
      if ($urandom_range(0, 99) == 0) q.side = 8'($urandom_range(0, 255));
    end else if (r < 98) begin
      q.op = ppsr_pkg::CMD_READ;
      // half the reads look at the page just drawn into
      if ($urandom_range(0, 1) == 0)
        q.addr = 10'((((last_y & 63) >> 3) * SCR_W) + (last_x & 127) + $urandom_range(0, 3));
    end else begin
      q.op = ppsr_pkg::CMD_CLEAR;
    end
    return q;
  endfunction

  // ---------------------------------------------------------------------------
  // driver, receiver and idle pacing
  // ---------------------------------------------------------------------------
  int          in_count  = 0;
  int          out_count = 0;
  int          calm_from = 0;
  int          hold_at   = 0;
  int          gap_left  = 0;
  int          stall_left = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  logic [31:0] cyc_count = '0;
  int          tx_rate   = 0;
  int          rx_rate   = 0;

  // idle density is redrawn whenever the low byte of the cycle counter wraps, zero gives stretches with no idling
  always @(posedge clk) begin
    cyc_count <= cyc_count + 1;
    if (cyc_count[7:0] == 8'd0) begin
      tx_rate <= $urandom_range(0, 3);
      rx_rate <= $urandom_range(0, 3);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (!in_valid || in_ready) begin
      // slot is free: the last transaction went through or nothing was offered
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pend_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (pend_q[0].drain && (in_valid || due_results.size() != 0)) begin
        in_valid <= 1'b0;
      end else begin
        in_valid    <= 1'b1;
        cmd         <= pend_q[0].op;
        pos_x       <= pend_q[0].x;
        pos_y       <= pend_q[0].y;
        width_px    <= pend_q[0].w;
        height_px   <= pend_q[0].h;
        side_len    <= pend_q[0].side;
        orientation <= pend_q[0].ori;
        fill_mode   <= pend_q[0].mode;
        read_addr   <= pend_q[0].addr;
        void'(pend_q.pop_front());
        // keep offering during the long receiver hold so the block backs up
        if (in_count < calm_from && hold_left == 0 && $urandom_range(0, 7) < tx_rate)
          gap_left <= $urandom_range(1, 8);
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
      hold_left  <= 0;
    end else if (!hold_done && in_count >= hold_at) begin
      hold_done <= 1'b1;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (in_count < calm_from && $urandom_range(0, 7) < rx_rate) begin
      stall_left <= $urandom_range(0, 7);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predict on input transactions, check on output transactions
  // ---------------------------------------------------------------------------
  int mism_count  = 0;
  int quiet_cycles = 0;
  int n_rect = 0, n_tri = 0, n_read = 0, n_clear = 0;
  int n_clipped = 0, n_lit_reads = 0;

  always @(posedge clk) begin
    shape_req_t seen;
    shape_ans_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        seen.op    = ppsr_pkg::cmd_t'(cmd);
        seen.x     = pos_x;
        seen.y     = pos_y;
        seen.w     = width_px;
        seen.h     = height_px;
        seen.side  = side_len;
        seen.ori   = ppsr_pkg::orient_t'(orientation);
        seen.mode  = ppsr_pkg::mode_t'(fill_mode);
        seen.addr  = read_addr;
        seen.drain = 1'b0;
        case (seen.op)
          ppsr_pkg::CMD_RECT: n_rect++;
          ppsr_pkg::CMD_TRI:  n_tri++;
          ppsr_pkg::CMD_READ: n_read++;
          default:            n_clear++;
        endcase
        due_results.push_back(render_command(seen));
        in_count++;
      end
      if (out_valid && out_ready) begin
        out_count++;
        if (clipped === 1'b1) n_clipped++;
        if (read_byte != 8'h00) n_lit_reads++;
        if (due_results.size() == 0) begin
          mism_count++;
          if (mism_count <= 10)
            $display("result %0d arrived with nothing outstanding: read_byte %02h clipped %0b",
                     out_count, read_byte, clipped);
        end else begin
          want = due_results.pop_front();
          if (read_byte !== want.rd_val || clipped !== want.clip) begin
            mism_count++;
            if (mism_count <= 10)
              $display("result %0d: read_byte exp %02h got %02h, clipped exp %0b got %0b",
                       out_count, want.rd_val, read_byte, want.clip, clipped);
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  // watchdog: too long without any transaction on either side
  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("no transaction for %0d cycles, %0d results outstanding",
             STALL_LIMIT, due_results.size());
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    shape_req_t q;

    // directed: empty frame, single corner pixels, extreme positions and sizes,
    // zero width and height, every fill mode including the unused one,
    // every triangle direction, zero length triangle, clear and reread
    pend_q.push_back(mk_req(ppsr_pkg::CMD_READ, 0, 0, 0, 0, 0,
                            ppsr_pkg::ORI_RIGHT, ppsr_pkg::MODE_FULL, 0));
    pend_q.push_back(mk_req(ppsr_pkg::CMD_READ, 0, 0, 0, 0, 0,
                            ppsr_pkg::ORI_RIGHT, ppsr_pkg::MODE_FULL, 1023));
    pend_q.push_back(mk_req(ppsr_pkg::CMD_RECT, 0, 0, 1, 1, 0,
                            ppsr_pkg::ORI_RIGHT, ppsr_pkg::MODE_FULL, 0));
    pend_q.push_back(mk_req(ppsr_pkg::CMD_READ, 0, 0, 0, 0, 0,
                            ppsr_pkg::ORI_RIGHT, ppsr_pkg::MODE_FULL, 0));
    pend_q.push_back(mk_req(ppsr_pkg::CMD_RECT, 127, 63, 1, 1, 0,
                            ppsr_pkg::ORI_RIGHT, ppsr_pkg::MODE_FULL, 0));
    pend_q.push_back(mk_req(ppsr_pkg::CMD_READ, 0, 0, 0, 0, 0,
                            ppsr_pkg::ORI_RIGHT, ppsr_pkg::MODE_FULL, 1023));
    pend_q.push_back(mk_req(ppsr_pkg::CMD_RECT, -256, -256, 255, 255, 255,
                            ppsr_pkg::ORI_UP, ppsr_pkg::MODE_FULL, 0));
    pend_q.push_back(mk_req(ppsr_pkg::CMD_RECT, 255, 255, 0, 5, 0,
                            ppsr_pkg::ORI_RIGHT, ppsr_pkg::MODE_FULL, 0));
    pend_q.push_back(mk_req(ppsr_pkg::CMD_RECT, -5, -5, 7, 0, 0,
                            ppsr_pkg::ORI_RIGHT, ppsr_pkg::MODE_FULL, 0));
    pend_q.push_back(mk_req(ppsr_pkg::CMD_RECT, 10, 8, 8, 8, 0,
                            ppsr_pkg::ORI_RIGHT, ppsr_pkg::MODE_OUTLINE, 0));
    pend_q.push_back(mk_req(ppsr_pkg::CMD_READ, 0, 0, 0, 0, 0,
                            ppsr_pkg::ORI_RIGHT, ppsr_pkg::MODE_FULL, 138));
    pend_q.push_back(mk_req(ppsr_pkg::CMD_READ, 0, 0, 0, 0, 0,
                            ppsr_pkg::ORI_RIGHT, ppsr_pkg::MODE_FULL, 139));
    pend_q.push_back(mk_req(ppsr_pkg::CMD_RECT, 120, 60, 16, 8, 0,
                            ppsr_pkg::ORI_RIGHT, ppsr_pkg::MODE_OUTLINE, 0));
    pend_q.push_back(mk_req(ppsr_pkg::CMD_RECT, 30, 30, 5, 5, 0,
                            ppsr_pkg::ORI_RIGHT, ppsr_pkg::MODE_TRI_OUTLINE, 0));
    pend_q.push_back(mk_req(ppsr_pkg::CMD_RECT, -3, -3, 5, 5, 0,
                            ppsr_pkg::ORI_RIGHT, ppsr_pkg::MODE_NONE, 0));
    pend_q.push_back(mk_req(ppsr_pkg::CMD_TRI, 20, 0, 0, 0, 9,
                            ppsr_pkg::ORI_RIGHT, ppsr_pkg::MODE_FULL, 0));
    pend_q.push_back(mk_req(ppsr_pkg::CMD_TRI, 20, 16, 0, 0, 9,
                            ppsr_pkg::ORI_LEFT, ppsr_pkg::MODE_FULL, 0));
    pend_q.push_back(mk_req(ppsr_pkg::CMD_TRI, 60, 0, 0, 0, 9,
                            ppsr_pkg::ORI_DOWN, ppsr_pkg::MODE_OUTLINE, 0));
    pend_q.push_back(mk_req(ppsr_pkg::CMD_TRI, 60, 40, 0, 0, 10,
                            ppsr_pkg::ORI_UP, ppsr_pkg::MODE_TRI_OUTLINE, 0));
    pend_q.push_back(mk_req(ppsr_pkg::CMD_TRI, 100, 20, 0, 0, 0,
                            ppsr_pkg::ORI_DOWN, ppsr_pkg::MODE_FULL, 0));
    pend_q.push_back(mk_req(ppsr_pkg::CMD_TRI, -20, -20, 0, 0, 255,
                            ppsr_pkg::ORI_DOWN, ppsr_pkg::MODE_FULL, 0));
    pend_q.push_back(mk_req(ppsr_pkg::CMD_TRI, 5, 5, 0, 0, 7,
                            ppsr_pkg::ORI_UP, ppsr_pkg::MODE_NONE, 0));
    pend_q.push_back(mk_req(ppsr_pkg::CMD_RECT, -1, -1, 200, 80, 0,
                            ppsr_pkg::ORI_RIGHT, ppsr_pkg::MODE_OUTLINE, 0));
    pend_q.push_back(mk_req(ppsr_pkg::CMD_READ, 0, 0, 0, 0, 0,
                            ppsr_pkg::ORI_RIGHT, ppsr_pkg::MODE_FULL, 20));
    pend_q.push_back(mk_req(ppsr_pkg::CMD_READ, 0, 0, 0, 0, 0,
                            ppsr_pkg::ORI_RIGHT, ppsr_pkg::MODE_FULL, 300));
    pend_q.push_back(mk_req(ppsr_pkg::CMD_CLEAR, 0, 0, 0, 0, 0,
                            ppsr_pkg::ORI_RIGHT, ppsr_pkg::MODE_FULL, 0));
    pend_q.push_back(mk_req(ppsr_pkg::CMD_READ, 0, 0, 0, 0, 0,
                            ppsr_pkg::ORI_RIGHT, ppsr_pkg::MODE_FULL, 138));

    hold_at = pend_q.size() + 40;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      q = random_req();
      // sender drains at the start, halfway and before the quiet tail
      if (i == 0 || i == RANDOM_ITEMS / 2 || i == RANDOM_ITEMS - CALM_TAIL) q.drain = 1'b1;
      pend_q.push_back(q);
    end
    calm_from = pend_q.size() - CALM_TAIL;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (pend_q.size() != 0 || in_valid) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("%0d transactions: %0d rectangles, %0d triangles, %0d reads, %0d clears",
             in_count, n_rect, n_tri, n_read, n_clear);
    $display("%0d results checked, %0d clipped draws, %0d reads with pixels set, %0d mismatches",
             out_count, n_clipped, n_lit_reads, mism_count);
    if (mism_count == 0 && due_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
